// ===== rtl/elvhome_pkg.sv =====
`timescale 1ns / 1ps

package elvhome_pkg;

    // Speed profile depth, in steps of 1/8 unit of distance
    localparam int PROFILE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PROFILE_ENTRIES);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_UP_SPEED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_BAND       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_PER_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CALIBRATE_SPEED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_SPEED        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_OFFSET       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_STEPS       = 3'd7;

    // Target of -1.0 in Q16.16 clears the target
    localparam logic [31:0] NO_TARGET = 32'hFFFF_0000;

    // Decay constants for the profile, Q1.31
    localparam logic [63:0] Q31_ONE   = 64'd2147483648;
    localparam logic [63:0] Q31_HALF  = 64'd1073741824;
    localparam logic [63:0] DECAY_Q31 = 64'd2094462088;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_MOVE      = 2'd1,
        KIND_CALIBRATE = 2'd2,
        KIND_LIMIT     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PROD,
        BK_SCALE,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        kind_t       kind;
        logic        clear_goal;
        logic [31:0] target_pos;
        logic [31:0] encoder_count;
    } item_t;

    typedef struct packed {
        logic [6:0]  max_speed;
        logic [6:0]  min_up_speed;
        logic [15:0] arrive_band;
        logic [23:0] distance_per_step;
        logic [7:0]  calibrate_speed;
        logic [7:0]  home_speed;
        logic [31:0] home_offset;
        logic [7:0]  stall_steps;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  motor_speed;
        logic        motor_write;
        logic [31:0] position;
        logic        calibration_busy;
        logic        homing_busy;
    } result_t;

    typedef logic [7:0] gain_table_t [PROFILE_ENTRIES];

    // Build the 1 - exp(-idx/40) gain table in Q0.8 by square and multiply
    function automatic gain_table_t build_gain_table();
        gain_table_t tab;
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] g;
        logic [31:0] k;
        for (int i = 0; i < PROFILE_ENTRIES; i++) begin
            acc = Q31_ONE;
            sq  = DECAY_Q31;
            k   = 32'(i);
            while (k != 32'd0) begin
                if (k[0]) begin
                    acc = (acc * sq + Q31_HALF) >> 31;
                end
                sq = (sq * sq + Q31_HALF) >> 31;
                k  = k >> 1;
            end
            g      = (Q31_ONE - acc + 64'd4194304) >> 23;
            tab[i] = (g > 64'd255) ? 8'd255 : g[7:0];
        end
        return tab;
    endfunction

    localparam gain_table_t GAIN_TABLE = build_gain_table();

endpackage

// ===== rtl/elevator_position_homing_control.sv =====
`timescale 1ns / 1ps

// Elevator position regulator with homing. Input transactions (tick, move,
// calibrate, limit switch) enter a two-entry queue and are carried out one
// at a time by the back end; each produces exactly one result transaction
// from a registered output stage. Commands are carried out in the idle state.
// A tick passes through the idle, product, scale and done states: distance
// and encoder difference, encoder product and distance magnitude, profile
// table lookup with rounding, then speed scaling, position integration and
// the commit of state and result. No clearing pass follows reset.
module elevator_position_homing_control (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,  // target_pos [31:0], encoder_count [63:32]
    input  logic [1:0]                         s_tuser,  // mode [1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [47:0]                        m_tdata,  // motor_speed [7:0], position [39:8],
                                                         // calibration_busy [40], homing_busy [41]
    output logic [0:0]                         m_tuser,  // motor_write [0]
    input  logic                               cfg_wr_en,
    input  logic [elvhome_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [elvhome_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import elvhome_pkg::*;

    cfg_t     cfg_reg;
    item_t    head;
    logic     head_valid;
    logic     pop;
    result_t  result;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_speed         <= 7'd70;
            cfg_reg.min_up_speed      <= 7'd5;
            cfg_reg.arrive_band       <= 16'd6554;
            cfg_reg.distance_per_step <= 24'd146065;
            cfg_reg.calibrate_speed   <= 8'hF1;
            cfg_reg.home_speed        <= 8'd30;
            cfg_reg.home_offset       <= 32'hFFFF_3333;
            cfg_reg.stall_steps       <= 8'd5;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_SPEED:         cfg_reg.max_speed         <= cfg_wdata[6:0];
                REG_MIN_UP_SPEED:      cfg_reg.min_up_speed      <= cfg_wdata[6:0];
                REG_ARRIVE_BAND:       cfg_reg.arrive_band       <= cfg_wdata[15:0];
                REG_DISTANCE_PER_STEP: cfg_reg.distance_per_step <= cfg_wdata[23:0];
                REG_CALIBRATE_SPEED:   cfg_reg.calibrate_speed   <= cfg_wdata[7:0];
                REG_HOME_SPEED:        cfg_reg.home_speed        <= cfg_wdata[7:0];
                REG_HOME_OFFSET:       cfg_reg.home_offset       <= cfg_wdata[31:0];
                REG_STALL_STEPS:       cfg_reg.stall_steps       <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    elvhome_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    elvhome_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .result       (result),
        .result_valid (m_tvalid),
        .result_ready (m_tready)
    );

    // Pack the result transaction
    assign m_tdata = {6'd0, result.homing_busy, result.calibration_busy,
                      result.position, result.motor_speed};
    assign m_tuser = result.motor_write;

endmodule

// ===== rtl/elvhome_front.sv =====
`timescale 1ns / 1ps

module elvhome_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,   // target_pos [31:0], encoder_count [63:32]
    input  logic [1:0]          s_tuser,   // mode [1:0]
    output elvhome_pkg::item_t  head,
    output logic                head_valid,
    input  logic                pop
);
    import elvhome_pkg::*;

    item_t               queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                push;
    item_t               incoming;

    // Classify the incoming transaction
    always_comb begin
        incoming.kind          = kind_t'(s_tuser);
        incoming.clear_goal    = (s_tdata[31:0] == NO_TARGET);
        incoming.target_pos    = s_tdata[31:0];
        incoming.encoder_count = s_tdata[63:32];
    end

    assign s_tready   = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/elvhome_back.sv =====
`timescale 1ns / 1ps

module elvhome_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  elvhome_pkg::cfg_t     cfg,
    input  elvhome_pkg::item_t    head,
    input  logic                  head_valid,
    output logic                  pop,
    output elvhome_pkg::result_t  result,
    output logic                  result_valid,
    input  logic                  result_ready
);
    import elvhome_pkg::*;

    back_state_t        state_reg, state_next;

    // Regulator state
    logic [31:0]        cur_pos_reg, cur_pos_next;
    logic [31:0]        last_enc_reg, last_enc_next;
    logic [7:0]         last_spd_reg, last_spd_next;
    logic [31:0]        goal_reg, goal_next;
    logic               goal_valid_reg, goal_valid_next;
    logic               cal_reg, cal_next;
    logic               hom_reg, hom_next;

    // Tick pipeline registers
    logic signed [32:0] d_reg;
    logic [31:0]        delta_reg;
    logic [31:0]        dist_reg;
    logic signed [55:0] prod_reg;
    logic               up_reg;
    logic               drive_reg;
    logic [7:0]         gain_reg;
    logic [47:0]        inc_reg;

    // Output register
    result_t            out_reg, out_next;
    logic               out_valid_reg;
    logic               load_out;
    logic               out_free;

    // Tick datapath
    logic signed [32:0] d_w;
    logic [32:0]        dist_w;
    logic signed [56:0] prod_w;
    logic signed [55:0] rnd_w;
    logic               idx_over;
    logic [IDX_W-1:0]   idx_w;
    logic [14:0]        mag_prod;
    logic [6:0]         mag;
    logic [6:0]         up_mag;
    logic [7:0]         tgt;
    logic signed [48:0] sum_w;
    logic [31:0]        np;
    logic               stalled;

    logic               wr;
    logic [7:0]         spd;

    assign out_free     = !out_valid_reg || result_ready;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // Distance, its magnitude and the encoder product
    assign d_w    = $signed({goal_reg[31], goal_reg}) - $signed({cur_pos_reg[31], cur_pos_reg});
    assign dist_w = d_reg[32] ? (33'd0 - d_reg) : d_reg;
    assign prod_w = $signed(delta_reg) * $signed({1'b0, cfg.distance_per_step});

    // Round half away from zero before dropping eight bits
    assign rnd_w  = prod_reg + (prod_reg[55] ? 56'sd127 : 56'sd128);

    // Profile index, saturated at the last entry
    assign idx_over = (dist_reg[31:13] >= 19'(PROFILE_ENTRIES));
    assign idx_w    = idx_over ? IDX_W'(PROFILE_ENTRIES-1) : dist_reg[13 +: IDX_W];

    // Scale profile gain to speed and clamp
    assign mag_prod = cfg.max_speed * gain_reg;
    assign mag      = mag_prod[14:8];

    always_comb begin
        up_mag = (mag > cfg.max_speed) ? cfg.max_speed : mag;
        if (up_mag < cfg.min_up_speed) begin
            up_mag = cfg.min_up_speed;
        end
        if (!drive_reg) begin
            tgt = 8'd0;
        end else if (up_reg) begin
            tgt = {1'b0, up_mag};
        end else begin
            tgt = 8'd0 - {1'b0, mag};
        end
    end

    // Integrate position with saturation
    assign sum_w = $signed({{17{cur_pos_reg[31]}}, cur_pos_reg}) + $signed({inc_reg[47], inc_reg});
    always_comb begin
        if (sum_w[48:31] != {18{sum_w[48]}}) begin
            np = sum_w[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            np = sum_w[31:0];
        end
    end

    assign stalled = $signed(delta_reg) < $signed({24'd0, cfg.stall_steps});

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (head_valid && head.kind == KIND_TICK) begin
                    state_next = BK_PROD;
                end
            end
            BK_PROD:  state_next = BK_SCALE;
            BK_SCALE: state_next = BK_DONE;
            BK_DONE: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    // Outputs and state updates
    always_comb begin
        pop             = 1'b0;
        load_out        = 1'b0;
        wr              = 1'b0;
        spd             = 8'd0;
        cur_pos_next    = cur_pos_reg;
        last_enc_next   = last_enc_reg;
        last_spd_next   = last_spd_reg;
        goal_next       = goal_reg;
        goal_valid_next = goal_valid_reg;
        cal_next        = cal_reg;
        hom_next        = hom_reg;

        case (state_reg)
            BK_IDLE: begin
                if (head_valid) begin
                    if (head.kind == KIND_TICK) begin
                        pop           = 1'b1;
                        last_enc_next = head.encoder_count;
                    end else if (out_free) begin
                        pop      = 1'b1;
                        load_out = 1'b1;
                        case (head.kind)
                            KIND_MOVE: begin
                                goal_next       = head.target_pos;
                                goal_valid_next = !head.clear_goal;
                            end
                            KIND_CALIBRATE: begin
                                wr       = 1'b1;
                                spd      = cfg.calibrate_speed;
                                cal_next = 1'b1;
                            end
                            KIND_LIMIT: begin
                                if (cal_reg) begin
                                    wr           = 1'b1;
                                    spd          = cfg.home_speed;
                                    cur_pos_next = cfg.home_offset;
                                    cal_next     = 1'b0;
                                    hom_next     = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    cur_pos_next = np;
                    if (!cal_reg && !hom_reg && tgt != last_spd_reg) begin
                        wr            = 1'b1;
                        spd           = tgt;
                        last_spd_next = tgt;
                    end
                    if (hom_reg) begin
                        if (!np[31]) begin
                            wr       = 1'b1;
                            spd      = 8'd0;
                            hom_next = 1'b0;
                        end else if (stalled) begin
                            wr  = 1'b1;
                            spd = cfg.home_speed;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        out_next.motor_speed      = wr ? spd : 8'd0;
        out_next.motor_write      = wr;
        out_next.position         = cur_pos_next;
        out_next.calibration_busy = cal_next;
        out_next.homing_busy      = hom_next;
    end

    // Tick pipeline: difference, product, lookup
    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                d_reg     <= d_w;
                delta_reg <= head.encoder_count - last_enc_reg;
            end
            BK_PROD: begin
                dist_reg <= dist_w[31:0];
                prod_reg <= prod_w[55:0];
                up_reg   <= !d_reg[32] && (d_reg != '0);
            end
            BK_SCALE: begin
                gain_reg  <= GAIN_TABLE[idx_w];
                drive_reg <= goal_valid_reg && (dist_reg >= {16'd0, cfg.arrive_band});
                inc_reg   <= rnd_w[55:8];
            end
            default: begin
            end
        endcase
    end

    // Hold the result for the output channel
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            out_valid_reg  <= 1'b0;
            cur_pos_reg    <= '0;
            last_enc_reg   <= '0;
            last_spd_reg   <= '0;
            goal_reg       <= '0;
            goal_valid_reg <= 1'b0;
            cal_reg        <= 1'b0;
            hom_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_pos_reg    <= cur_pos_next;
            last_enc_reg   <= last_enc_next;
            last_spd_reg   <= last_spd_next;
            goal_reg       <= goal_next;
            goal_valid_reg <= goal_valid_next;
            cal_reg        <= cal_next;
            hom_reg        <= hom_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (result_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
